/* src/trz_pkg.sv */
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants of the triangle rasterizer with depth buffer.
// ----------------------------------------------------------------------------
package trz_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register indexes
  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  // corner slot that starts drawing
  localparam logic [1:0] SLOT_DRAW = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  localparam int ED    = 17;  // corner coordinate difference
  localparam int DETW  = 33;  // magnitude of the edge determinant
  localparam int MW    = 60;  // numerator accumulator and remainder
  localparam int VW    = 24;  // interpolated value
  localparam int KW    = 5;   // bit counter of multiply and divide
  localparam int NLANE = 4;   // depth, red, green, blue
  localparam int RAMW  = 48;  // depth and colour of one pixel

  localparam logic [KW-1:0]  KTOP       = KW'(VW - 1);
  localparam logic [VW-1:0]  DEPTH_MAX  = 24'h7FFFFF;
  localparam logic [VW-1:0]  DEPTH_BIAS = 24'h800000;
  localparam logic [8:0]     SIZE_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [23:0] pos_depth;
    logic [7:0]         vert_red;
    logic [7:0]         vert_green;
    logic [7:0]         vert_blue;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } trz_in_t;

  typedef struct packed {
    logic [1:0]         done_op;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
    logic signed [23:0] pixel_depth;
    logic [16:0]        pixels_written;
  } trz_out_t;

  typedef struct packed {
    logic [0:0] index;
    logic [8:0] data;
  } trz_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_RDATA,
    ST_SETUP0,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_SCAN,
    ST_MAC,
    ST_DIV,
    ST_CMP,
    ST_DONE
  } trz_state_t;

endpackage

/* src/trz_if.sv */
// ----------------------------------------------------------------------------
// trz_if
// Valid/ready channels of the rasterizer: input items, results, registers.
// ----------------------------------------------------------------------------
interface trz_in_if;
  import trz_pkg::*;
  logic    valid;
  logic    ready;
  trz_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trz_out_if;
  import trz_pkg::*;
  logic     valid;
  logic     ready;
  trz_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trz_cfg_if;
  import trz_pkg::*;
  logic     valid;
  logic     ready;
  trz_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/trz_ram.sv */
// ----------------------------------------------------------------------------
// trz_ram
// Generic single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module trz_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* src/triangle_rasterizer_zbuffer.sv */
// ----------------------------------------------------------------------------
// triangle_rasterizer_zbuffer
// Barycentric triangle rasterizer writing a depth and colour frame store.
// ----------------------------------------------------------------------------
// loads of slots 0, 1 and 3, reads out of range and unused codes go straight to done;
//   a read passes the read and read-data states; clear writes one frame store entry per cycle
// draw: setup states SETUP0 to SETUP3, then a scan of the clamped bounding box in which
//   pixels outside the triangle are stepped over and each covered pixel takes a 24-step serial
//   multiply-accumulate, a 24-step restoring divide, and a depth compare and write
// one item in flight at a time; a finished result waits in the output
//   register while the next item is accepted
// reset (synchronous, active low) clears control and corners and sets the size registers to 256;
//   the frame store holds garbage until the first clear item
module triangle_rasterizer_zbuffer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input logic       clk,
  input logic       rst_n,
  trz_in_if.sink    in_ch,
  trz_out_if.source out_ch,
  trz_cfg_if.sink   cfg_ch
);
  import trz_pkg::*;

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // signed pixel coordinate, wide enough for floor/ceil of any corner
  localparam int CRD   = ($clog2(MAXD) + 2 > 13) ? $clog2(MAXD) + 2 : 13;
  localparam int DW    = CRD + 5;           // pixel centre minus corner
  localparam int WW    = ED + DW + 1;       // edge function value
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // control
  trz_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic [8:0] width_r, height_r;

  // triangle corners
  logic signed [15:0] cx_r [3];
  logic signed [15:0] cy_r [3];
  logic signed [23:0] cz_r [3];
  logic [23:0]        cc_r [3];

  // payload registers
  trz_out_t               res_r, out_data_r;
  logic [AW-1:0]          idx_r, row_base_r;
  logic signed [CRD-1:0]  x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic signed [ED-1:0]   a0_r, b0_r, a1_r, b1_r, e2_r;
  logic signed [2*ED-1:0] p0_r, p1_r;
  logic [DETW-1:0]        det_abs_r;
  logic signed [DW-1:0]   dx_r, dy_r;
  logic signed [ED+DW-1:0] q0_r, q1_r, q2_r, q3_r;
  logic signed [WW-1:0]   w0_r, w1_r, rw0_r, rw1_r;
  logic [DETW-1:0]        wv_r [3];
  logic [MW-1:0]          val_r [NLANE];
  logic [MW-1:0]          dsh_r;
  logic [VW-1:0]          quo_r [NLANE];
  logic [KW-1:0]          k_r;

  // combinational
  logic                  accept;
  logic signed [CRD-1:0] eff_w, eff_h;
  logic                  read_in_range;
  logic [AW-1:0]         read_idx;
  logic signed [15:0]    mnx, mxx, mny, mxy;
  logic signed [16:0]    cex, cey;
  logic signed [CRD-1:0] flx, fly, clx, cly, x0n, x1n, y0n, y1n;
  logic signed [ED-1:0]  da0, db0, da1, db1, de2;
  logic signed [2*ED:0]  det;
  logic                  det_neg, draw_none;
  logic signed [CRD+3:0] px0, py0;
  logic signed [WW-1:0]  w2;
  logic                  covered, last_px, adv;
  logic [VW-1:0]         lv [NLANE][3];
  logic [MW-1:0]         mac_nxt [NLANE];
  logic [VW-1:0]         znew;
  logic                  z_pass;
  logic                  ram_we;
  logic [RAMW-1:0]       ram_wdata, ram_rdata;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // frame size in use: zero acts as one, large values saturate
  always_comb begin
    if (width_r == '0) begin
      eff_w = CRD'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = CRD'(MAX_WIDTH);
    end else begin
      eff_w = CRD'(width_r);
    end
    if (height_r == '0) begin
      eff_h = CRD'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = CRD'(MAX_HEIGHT);
    end else begin
      eff_h = CRD'(height_r);
    end
  end

  assign read_in_range = (CRD'(in_ch.data.read_col) < eff_w) &&
                         (CRD'(in_ch.data.read_row) < eff_h);
  assign read_idx = AW'(AW'(in_ch.data.read_row) * AW'(MAX_WIDTH)) +
                    AW'(in_ch.data.read_col);

  // bounding box of the corners, floor of min and ceil of max, clamped
  always_comb begin
    mnx = (cx_r[0] < cx_r[1]) ? cx_r[0] : cx_r[1];
    mnx = (mnx < cx_r[2]) ? mnx : cx_r[2];
    mxx = (cx_r[0] > cx_r[1]) ? cx_r[0] : cx_r[1];
    mxx = (mxx > cx_r[2]) ? mxx : cx_r[2];
    mny = (cy_r[0] < cy_r[1]) ? cy_r[0] : cy_r[1];
    mny = (mny < cy_r[2]) ? mny : cy_r[2];
    mxy = (cy_r[0] > cy_r[1]) ? cy_r[0] : cy_r[1];
    mxy = (mxy > cy_r[2]) ? mxy : cy_r[2];
    cex = 17'(mxx) + 17'sd15;
    cey = 17'(mxy) + 17'sd15;
    flx = CRD'(mnx >>> 4);
    fly = CRD'(mny >>> 4);
    clx = CRD'(cex >>> 4);
    cly = CRD'(cey >>> 4);
    x0n = (flx < 0) ? '0 : flx;
    y0n = (fly < 0) ? '0 : fly;
    x1n = (clx > eff_w - CRD'(1)) ? eff_w - CRD'(1) : clx;
    y1n = (cly > eff_h - CRD'(1)) ? eff_h - CRD'(1) : cly;
  end

  // edge coefficients from the corners
  assign da0 = ED'(cy_r[1]) - ED'(cy_r[2]);
  assign db0 = ED'(cx_r[2]) - ED'(cx_r[1]);
  assign da1 = ED'(cy_r[2]) - ED'(cy_r[0]);
  assign db1 = ED'(cx_r[0]) - ED'(cx_r[2]);
  assign de2 = ED'(cy_r[0]) - ED'(cy_r[2]);

  assign det       = (2*ED+1)'(p0_r) + (2*ED+1)'(p1_r);
  assign det_neg   = det[2*ED];
  assign draw_none = (det == '0) || (x0_r > x1_r) || (y0_r > y1_r);

  // first pixel centre in Q13.4
  assign px0 = $signed({x0_r, 4'b1000});
  assign py0 = $signed({y0_r, 4'b1000});

  // coverage at the current pixel, third weight from the other two
  assign w2      = WW'($signed({1'b0, det_abs_r})) - w0_r - w1_r;
  assign covered = !w0_r[WW-1] && !w1_r[WW-1] && !w2[WW-1];
  assign last_px = (x_r == x1_r) && (y_r == y1_r);
  assign adv     = ((state_r == ST_SCAN) && !covered) || (state_r == ST_CMP);

  // interpolated lanes: biased depth and the three colours
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lv[0][i] = {~cz_r[i][VW-1], cz_r[i][VW-2:0]};
      lv[1][i] = VW'(cc_r[i][23:16]);
      lv[2][i] = VW'(cc_r[i][15:8]);
      lv[3][i] = VW'(cc_r[i][7:0]);
    end
  end

  // one numerator bit per cycle, most significant first
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      mac_nxt[l] = (val_r[l] << 1) +
                   (lv[l][0][k_r] ? MW'(wv_r[0]) : '0) +
                   (lv[l][1][k_r] ? MW'(wv_r[1]) : '0) +
                   (lv[l][2][k_r] ? MW'(wv_r[2]) : '0);
    end
  end

  // depth test, equal depth passes
  assign znew   = quo_r[0] ^ DEPTH_BIAS;
  assign z_pass = $signed(znew) <= $signed(ram_rdata[RAMW-1:VW]);

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_CMP) && z_pass);
  assign ram_wdata = (state_r == ST_CLEAR) ? {DEPTH_MAX, 24'h0} :
                     {znew, quo_r[1][7:0], quo_r[2][7:0], quo_r[3][7:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.data.op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_LOAD: begin
              state_nxt = (in_ch.data.vertex_slot == SLOT_DRAW) ? ST_SETUP0 : ST_DONE;
            end
            OP_READ: state_nxt = read_in_range ? ST_READ : ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR:  if (idx_r == AW'(DEPTH - 1)) state_nxt = ST_DONE;
      ST_READ:   state_nxt = ST_RDATA;
      ST_RDATA:  state_nxt = ST_DONE;
      ST_SETUP0: state_nxt = ST_SETUP1;
      ST_SETUP1: state_nxt = draw_none ? ST_DONE : ST_SETUP2;
      ST_SETUP2: state_nxt = ST_SETUP3;
      ST_SETUP3: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (covered) begin
          state_nxt = ST_MAC;
        end else if (last_px) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MAC:    if (k_r == '0) state_nxt = ST_DIV;
      ST_DIV:    if (k_r == '0) state_nxt = ST_CMP;
      ST_CMP:    state_nxt = last_px ? ST_DONE : ST_SCAN;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= SIZE_RESET;
      height_r    <= SIZE_RESET;
      for (int i = 0; i < 3; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
        cz_r[i] <= '0;
        cc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == CFG_WIDTH) begin
          width_r <= cfg_ch.data.data;
        end else begin
          height_r <= cfg_ch.data.data;
        end
      end
      // corner store, slot three stores nothing
      if (accept && (in_ch.data.op == OP_LOAD) && (in_ch.data.vertex_slot != SLOT_NONE)) begin
        cx_r[in_ch.data.vertex_slot] <= in_ch.data.pos_x;
        cy_r[in_ch.data.vertex_slot] <= in_ch.data.pos_y;
        cz_r[in_ch.data.vertex_slot] <= in_ch.data.pos_depth;
        cc_r[in_ch.data.vertex_slot] <= {in_ch.data.vert_red, in_ch.data.vert_green,
                                         in_ch.data.vert_blue};
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_valid_r || out_ch.ready)) begin
      out_data_r <= res_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_r         <= '0;
          res_r.done_op <= in_ch.data.op;
          idx_r         <= (in_ch.data.op == OP_READ) ? read_idx : '0;
        end
      end
      ST_CLEAR: idx_r <= idx_r + AW'(1);
      ST_RDATA: begin
        res_r.pixel_depth <= ram_rdata[RAMW-1:VW];
        res_r.pixel_red   <= ram_rdata[23:16];
        res_r.pixel_green <= ram_rdata[15:8];
        res_r.pixel_blue  <= ram_rdata[7:0];
      end
      ST_SETUP0: begin
        a0_r <= da0;
        b0_r <= db0;
        a1_r <= da1;
        b1_r <= db1;
        e2_r <= de2;
        p0_r <= da0 * db1;
        p1_r <= db0 * de2;
        x0_r <= x0n;
        x1_r <= x1n;
        y0_r <= y0n;
        y1_r <= y1n;
      end
      ST_SETUP1: begin
        // orient the edges so inside weights come out positive
        a0_r       <= det_neg ? -a0_r : a0_r;
        b0_r       <= det_neg ? -b0_r : b0_r;
        a1_r       <= det_neg ? -a1_r : a1_r;
        b1_r       <= det_neg ? -b1_r : b1_r;
        det_abs_r  <= det_neg ? DETW'(-det) : DETW'(det);
        dx_r       <= DW'(px0) - DW'(cx_r[2]);
        dy_r       <= DW'(py0) - DW'(cy_r[2]);
        row_base_r <= AW'(AW'($unsigned(y0_r)) * AW'(MAX_WIDTH));
      end
      ST_SETUP2: begin
        q0_r <= a0_r * dx_r;
        q1_r <= b0_r * dy_r;
        q2_r <= a1_r * dx_r;
        q3_r <= b1_r * dy_r;
      end
      ST_SETUP3: begin
        w0_r  <= WW'(q0_r) + WW'(q1_r);
        w1_r  <= WW'(q2_r) + WW'(q3_r);
        rw0_r <= WW'(q0_r) + WW'(q1_r);
        rw1_r <= WW'(q2_r) + WW'(q3_r);
        x_r   <= x0_r;
        y_r   <= y0_r;
        idx_r <= row_base_r + AW'($unsigned(x0_r));
      end
      ST_SCAN: begin
        if (covered) begin
          wv_r[0] <= DETW'(w0_r);
          wv_r[1] <= DETW'(w1_r);
          wv_r[2] <= DETW'(w2);
          k_r     <= KTOP;
          for (int l = 0; l < NLANE; l++) begin
            val_r[l] <= '0;
          end
        end
      end
      ST_MAC: begin
        k_r <= k_r - KW'(1);
        for (int l = 0; l < NLANE; l++) begin
          val_r[l] <= mac_nxt[l];
        end
        if (k_r == '0) begin
          // rounding: floor((2*num + det) / (2*det))
          k_r   <= KTOP;
          dsh_r <= MW'({det_abs_r, 1'b0}) << KTOP;
          for (int l = 0; l < NLANE; l++) begin
            val_r[l] <= (mac_nxt[l] << 1) + MW'(det_abs_r);
          end
        end
      end
      ST_DIV: begin
        k_r   <= k_r - KW'(1);
        dsh_r <= dsh_r >> 1;
        for (int l = 0; l < NLANE; l++) begin
          if (val_r[l] >= dsh_r) begin
            val_r[l] <= val_r[l] - dsh_r;
            quo_r[l] <= {quo_r[l][VW-2:0], 1'b1};
          end else begin
            quo_r[l] <= {quo_r[l][VW-2:0], 1'b0};
          end
        end
      end
      ST_CMP: begin
        if (z_pass) begin
          res_r.pixels_written <= res_r.pixels_written + 17'd1;
        end
      end
      default: begin
      end
    endcase
    // raster walk: next column, or first column of the next row
    if (adv && !last_px) begin
      if (x_r == x1_r) begin
        x_r        <= x0_r;
        y_r        <= y_r + CRD'(1);
        rw0_r      <= rw0_r + (WW'(b0_r) <<< 4);
        rw1_r      <= rw1_r + (WW'(b1_r) <<< 4);
        w0_r       <= rw0_r + (WW'(b0_r) <<< 4);
        w1_r       <= rw1_r + (WW'(b1_r) <<< 4);
        row_base_r <= row_base_r + AW'(MAX_WIDTH);
        idx_r      <= row_base_r + AW'(MAX_WIDTH) + AW'($unsigned(x0_r));
      end else begin
        x_r   <= x_r + CRD'(1);
        w0_r  <= w0_r + (WW'(a0_r) <<< 4);
        w1_r  <= w1_r + (WW'(a1_r) <<< 4);
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  // frame store: depth and colour side by side
  trz_ram #(
    .WIDTH(RAMW),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  a_no_degenerate_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (det_abs_r != '0))
    else $error("scan with zero determinant");

  a_pixel_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (x_r >= x0_r && x_r <= x1_r && y_r >= y0_r && y_r <= y1_r))
    else $error("pixel written outside bounding box");

  a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |->
      (quo_r[1][VW-1:8] == '0 && quo_r[2][VW-1:8] == '0 && quo_r[3][VW-1:8] == '0))
    else $error("interpolated colour above full scale");

  a_count_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pixels_written == '0 || out_data_r.done_op == OP_LOAD))
    else $error("pixel count on a non-load item");
`endif

endmodule
